### rtl/core/p2cbr_pkg.sv
`timescale 1ns / 1ps

package p2cbr_pkg;

  localparam int RANGE_BINS   = 256;
  localparam int ANGLE_BINS   = 512;
  localparam int FRAC_BITS    = 8;
  localparam int RANGE_W      = 8;
  localparam int ANGLE_W      = 9;
  localparam int SAMPLE_W     = 16;
  localparam int OFS_W        = 9;
  localparam int PIX_W        = 24;

  localparam int CORDIC_STEPS = 24;
  localparam int CRD_W        = 34;
  localparam int ACC_W        = 32;
  localparam int PRESCALE     = 20;

  localparam int SQ_W         = 2 * OFS_W;
  localparam int ROOT_W       = 17;
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int REM_W        = ROOT_W + 4;

  localparam int BANK_AW      = RANGE_W + ANGLE_W - 2;
  localparam int BANK_DEPTH   = 1 << BANK_AW;
  localparam int WGT_W        = 2 * FRAC_BITS + 1;
  localparam int PROD_W       = WGT_W + SAMPLE_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int RND_SH       = 2 * FRAC_BITS - 8;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                        cmd;
    logic [ANGLE_W-1:0]          abin;
    logic [RANGE_W-1:0]          rbin;
    logic [SAMPLE_W-1:0]         smp;
    logic signed [OFS_W-1:0]     ox;
    logic signed [OFS_W-1:0]     oy;
  } p2cbr_req_t;

  typedef struct packed {
    logic                        vld;
    cmd_t                        cmd;
    logic [ANGLE_W-1:0]          abin;
    logic [RANGE_W-1:0]          rbin;
    logic [SAMPLE_W-1:0]         smp;
    logic                        zero;
    logic signed [CRD_W-1:0]     re;
    logic signed [CRD_W-1:0]     im;
    logic [ACC_W-1:0]            acc;
    logic [SQ_W-1:0]             sq;
    logic [REM_W-1:0]            rem;
    logic [ROOT_W-1:0]           root;
  } p2cbr_stage_t;

  function automatic logic [ACC_W-1:0] atan_turn(input int unsigned idx);
    logic [ACC_W-1:0] v;
    unique case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/polar_to_cartesian_bilinear_resampler_top.sv
`timescale 1ns / 1ps

// Polar-to-Cartesian bilinear resampler.
// Input channel (in_valid / in_stall) carries two kinds of item: in_cmd = write
// stores in_sample at (in_range_bin, in_angle_bin); in_cmd = query takes a pixel
// offset (in_offset_x, in_offset_y) from the radar center. Each query yields one
// item on the output channel (out_valid / out_stall): out_pixel_value is the
// bilinear blend of the four neighboring polar samples in unsigned Q16.8,
// out_out_of_range flags a range neighbor beyond the store. Writes yield nothing.
// Items of both kinds flow through one 28-stage pipeline in order, so a query
// sees exactly the writes accepted before it. One item is taken per cycle; the
// polar store is split into four banks by range and angle parity, so the four
// neighbors are read in the same cycle.
// While out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised; otherwise an item is accepted every cycle.
// Reset clears the pipeline valid bits only; store entries hold garbage until
// written.
module polar_to_cartesian_bilinear_resampler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [p2cbr_pkg::ANGLE_W-1:0]       in_angle_bin,
  input  logic [p2cbr_pkg::RANGE_W-1:0]       in_range_bin,
  input  logic [p2cbr_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic signed [p2cbr_pkg::OFS_W-1:0]  in_offset_x,
  input  logic signed [p2cbr_pkg::OFS_W-1:0]  in_offset_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [p2cbr_pkg::PIX_W-1:0]         out_pixel_value,
  output logic                                out_out_of_range
);
  import p2cbr_pkg::*;

  logic         adv;
  p2cbr_req_t   req;
  p2cbr_stage_t fin;

  logic                out_valid_r;
  logic [PIX_W-1:0]    out_pixel_value_r;
  logic                out_of_range_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_comb begin
    req.cmd  = cmd_t'(in_cmd);
    req.abin = in_angle_bin;
    req.rbin = in_range_bin;
    req.smp  = in_sample;
    req.ox   = in_offset_x;
    req.oy   = in_offset_y;
  end

  p2cbr_polar_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .req_vld (in_valid),
    .req     (req),
    .res     (fin)
  );

  // address and weight stage
  logic [ACC_W-1:0]           acc_f;
  logic [ANGLE_W+FRAC_BITS-1:0] theta;
  logic [ANGLE_W-1:0]         a0;
  logic [ANGLE_W-1:0]         a1;
  logic [FRAC_BITS-1:0]       wa;
  logic [ANGLE_W-1:0]         r0;
  logic [ANGLE_W:0]           r1;
  logic [FRAC_BITS-1:0]       wr;
  logic [FRAC_BITS:0]         wac;
  logic [FRAC_BITS:0]         wrc;
  logic                       oor0;
  logic                       oor1;
  logic [BANK_AW-1:0]         rd_addr [4];
  logic [3:0]                 wr_en;
  logic [BANK_AW-1:0]         wr_addr;
  logic                       do_wr;

  always_comb begin
    acc_f = fin.zero ? (ACC_W'(1) << (ACC_W - 2)) : fin.acc;
    theta = acc_f[ACC_W-1 -: ANGLE_W+FRAC_BITS];
    a0    = theta[ANGLE_W+FRAC_BITS-1:FRAC_BITS];
    wa    = theta[FRAC_BITS-1:0];
    a1    = a0 + ANGLE_W'(1);
    r0    = fin.root[ROOT_W-1:FRAC_BITS];
    wr    = fin.root[FRAC_BITS-1:0];
    r1    = {1'b0, r0} + (ANGLE_W+1)'(1);
    wac   = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(wa);
    wrc   = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(wr);
    oor0  = {1'b0, r0} >= (ANGLE_W+1)'(RANGE_BINS);
    oor1  = r1 >= (ANGLE_W+1)'(RANGE_BINS);
    for (int b = 0; b < 4; b++) begin
      logic [ANGLE_W-1:0] rsel;
      logic [ANGLE_W-1:0] asel;
      rsel = (r0[0] == b[1]) ? r0 : r1[ANGLE_W-1:0];
      asel = (a0[0] == b[0]) ? a0 : a1;
      rd_addr[b] = {rsel[RANGE_W-1:1], asel[ANGLE_W-1:1]};
    end
    do_wr   = adv && fin.vld && (fin.cmd == CMD_WRITE);
    wr_addr = {fin.rbin[RANGE_W-1:1], fin.abin[ANGLE_W-1:1]};
    for (int b = 0; b < 4; b++) begin
      wr_en[b] = do_wr && ({fin.rbin[0], fin.abin[0]} == 2'(b));
    end
  end

  logic [SAMPLE_W-1:0] bank_rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [SAMPLE_W-1:0] mem [BANK_DEPTH];
    logic [SAMPLE_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (wr_en[b]) begin
        mem[wr_addr] <= fin.smp;
      end
      if (adv) begin
        rd_q <= mem[rd_addr[b]];
      end
    end

    assign bank_rd[b] = rd_q;
  end

  logic              m1_vld_r;
  cmd_t              m1_cmd_r;
  logic [WGT_W-1:0]  m1_w_r [4];
  logic              m1_r0l_r;
  logic              m1_a0l_r;
  logic              m1_oor0_r;
  logic              m1_oor1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_cmd_r  <= fin.cmd;
      m1_w_r[0] <= WGT_W'(wrc * wac);
      m1_w_r[1] <= WGT_W'(wrc * wa);
      m1_w_r[2] <= WGT_W'(wr * wac);
      m1_w_r[3] <= WGT_W'(wr * wa);
      m1_r0l_r  <= r0[0];
      m1_a0l_r  <= a0[0];
      m1_oor0_r <= oor0;
      m1_oor1_r <= oor1;
    end
  end

  // product stage
  logic [SAMPLE_W-1:0] nb [4];
  logic                m2_vld_r;
  cmd_t                m2_cmd_r;
  logic                m2_oor_r;
  logic [PROD_W-1:0]   m2_p_r [4];

  always_comb begin
    nb[0] = bank_rd[{m1_r0l_r, m1_a0l_r}];
    nb[1] = bank_rd[{m1_r0l_r, ~m1_a0l_r}];
    nb[2] = bank_rd[{~m1_r0l_r, m1_a0l_r}];
    nb[3] = bank_rd[{~m1_r0l_r, ~m1_a0l_r}];
    if (m1_oor0_r) begin
      nb[0] = '0;
      nb[1] = '0;
    end
    if (m1_oor1_r) begin
      nb[2] = '0;
      nb[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_cmd_r <= m1_cmd_r;
      m2_oor_r <= m1_oor0_r || m1_oor1_r;
      for (int i = 0; i < 4; i++) begin
        m2_p_r[i] <= PROD_W'(m1_w_r[i] * nb[i]);
      end
    end
  end

  // sum, round, output register
  logic [SUM_W-1:0] sum_rnd;
  logic             out_valid_nxt;

  always_comb begin
    sum_rnd = SUM_W'(m2_p_r[0]) + SUM_W'(m2_p_r[1]) + SUM_W'(m2_p_r[2])
            + SUM_W'(m2_p_r[3]) + SUM_W'(1 << (RND_SH - 1));
    out_valid_nxt = m2_vld_r && (m2_cmd_r == CMD_QUERY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_value_r <= sum_rnd[RND_SH +: PIX_W];
      out_of_range_r    <= m2_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pixel_value_r;
  assign out_out_of_range = out_of_range_r;

endmodule

### rtl/core/p2cbr_polar_pipe.sv
`timescale 1ns / 1ps

module p2cbr_polar_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  req_vld,
  input  p2cbr_pkg::p2cbr_req_t req,
  output p2cbr_pkg::p2cbr_stage_t res
);
  import p2cbr_pkg::*;

  p2cbr_stage_t stg_r [CORDIC_STEPS+1];
  p2cbr_stage_t entry_nxt;

  logic signed [SQ_W-1:0]  xx;
  logic signed [SQ_W-1:0]  yy;
  logic signed [CRD_W-1:0] re0;
  logic signed [CRD_W-1:0] im0;

  always_comb begin
    xx  = SQ_W'(req.ox) * SQ_W'(req.ox);
    yy  = SQ_W'(req.oy) * SQ_W'(req.oy);
    re0 = CRD_W'(req.ox) <<< PRESCALE;
    im0 = CRD_W'(req.oy) <<< PRESCALE;
    entry_nxt      = '0;
    entry_nxt.vld  = req_vld;
    entry_nxt.cmd  = req.cmd;
    entry_nxt.abin = req.abin;
    entry_nxt.rbin = req.rbin;
    entry_nxt.smp  = req.smp;
    entry_nxt.zero = (req.ox == '0) && (req.oy == '0);
    entry_nxt.sq   = SQ_W'(xx) + SQ_W'(yy);
    if (req.ox < 0) begin
      entry_nxt.re  = -re0;
      entry_nxt.im  = -im0;
      entry_nxt.acc = ACC_W'(1) << (ACC_W - 1);
    end else begin
      entry_nxt.re  = re0;
      entry_nxt.im  = im0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0].vld <= 1'b0;
    end else if (en) begin
      stg_r[0] <= entry_nxt;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    localparam logic [ACC_W-1:0] ATAN_K = atan_turn(k);
    localparam int SQ_BIT = (k < SQRT_STEPS) ? (2*ROOT_W-1-2*k) : 1;
    p2cbr_stage_t            stg_nxt;
    logic signed [CRD_W-1:0] cur_re;
    logic signed [CRD_W-1:0] cur_im;
    logic signed [CRD_W-1:0] dre;
    logic signed [CRD_W-1:0] dim;

    function automatic logic [REM_W-1:0] sqrt_rem_t(input p2cbr_stage_t s);
      logic [2*ROOT_W-1:0] nfull;
      logic [REM_W-1:0]    rt;
      nfull = {s.sq, {(2*ROOT_W-SQ_W){1'b0}}};
      rt    = {s.rem[REM_W-3:0], nfull[SQ_BIT -: 2]};
      return rt;
    endfunction

    function automatic logic [REM_W-1:0] sqrt_trial(input p2cbr_stage_t s);
      return REM_W'({s.root, 2'b01});
    endfunction

    function automatic logic [REM_W-1:0] sqrt_rem(input p2cbr_stage_t s);
      logic [REM_W-1:0] rt;
      logic [REM_W-1:0] tr;
      rt = sqrt_rem_t(s);
      tr = sqrt_trial(s);
      return (rt >= tr) ? rt - tr : rt;
    endfunction

    function automatic logic [ROOT_W-1:0] sqrt_root(input p2cbr_stage_t s);
      logic [REM_W-1:0] rt;
      logic [REM_W-1:0] tr;
      rt = sqrt_rem_t(s);
      tr = sqrt_trial(s);
      return {s.root[ROOT_W-2:0], (rt >= tr)};
    endfunction

    always_comb begin
      stg_nxt = stg_r[k];
      cur_re  = stg_r[k].re;
      cur_im  = stg_r[k].im;
      dre     = cur_im >>> k;
      dim     = cur_re >>> k;
      if (cur_im > 0) begin
        stg_nxt.re  = cur_re + dre;
        stg_nxt.im  = cur_im - dim;
        stg_nxt.acc = stg_r[k].acc + ATAN_K;
      end else begin
        stg_nxt.re  = cur_re - dre;
        stg_nxt.im  = cur_im + dim;
        stg_nxt.acc = stg_r[k].acc - ATAN_K;
      end
      if (k < SQRT_STEPS) begin
        stg_nxt.rem  = sqrt_rem(stg_r[k]);
        stg_nxt.root = sqrt_root(stg_r[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[k+1].vld <= 1'b0;
      end else if (en) begin
        stg_r[k+1] <= stg_nxt;
      end
    end
  end

  assign res = stg_r[CORDIC_STEPS];

endmodule
